// ----- rtl/core/jsu_pkg.sv -----
// Shared types, character codes and helpers for the quoted string decoder.
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// Decoder phase, one-hot
	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_STR  = 4'b0010,
		PH_ESC  = 4'b0100,
		PH_HEX  = 4'b1000
	} phase_t;

	// Character codes
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HT     = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BS     = 8'h08;

	// Last of the four bytes after a \u escape
	localparam logic [1:0] HEX_LAST = 2'd3;

	// One result transaction
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} result_t;

	// Decoder output for the item held in the input register
	typedef struct packed {
		logic    any;   // at least one result
		logic    two;   // two results
		result_t r0;
		result_t r1;
	} dec_t;

	// Hex digit value, bit 4 set when the byte is a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] res;
		res = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			res = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			res = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			res = {1'b1, 4'(c - 8'h37)};
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/json_string_unescape.sv -----
// Top level of the quoted string decoder: input register, config, decoder, result buffer.
//
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall  | data_byte, stream_end
//  out     | from block| out_valid/out_stall| out_byte, kind, last
//  cfg     | to block  | cfg_we             | cfg_wdata (strict_mode)
//
// One input byte per cycle while in_stall is low; out_valid comes from the output slot.
// An unknown escape gives two results and can hold the input side until the buffer frees.
// Rate is set by the single output slot: one result leaves per cycle while out_stall is low.
// arst_n clears the string state, the valid flags and sets strict mode.
// in_stall rises when the input register cannot move into the result buffer.
`timescale 1ns / 1ps
`default_nettype none
module json_string_unescape
	import jsu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       stream_end,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic [1:0]      kind,
	output logic            last
);

	logic       strict_q;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       end_s1;
	logic       commit;
	logic       buf_free;
	logic       in_take;
	dec_t       dec;
	result_t    slot;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b1;
		end else if (cfg_we) begin
			strict_q <= cfg_wdata;
		end
	end

	// Held item moves on when it yields nothing or the buffer has room
	assign commit   = valid_s1 && (!dec.any || buf_free);
	assign in_stall = valid_s1 && !commit;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			end_s1  <= stream_end;
		end
	end

	jsu_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit      (commit),
		.item_data   (data_s1),
		.item_end    (end_s1),
		.strict_mode (strict_q),
		.dec         (dec)
	);

	jsu_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (commit && dec.any),
		.push_two (dec.two),
		.r0       (dec.r0),
		.r1       (dec.r1),
		.stall    (out_stall),
		.free     (buf_free),
		.valid    (out_valid),
		.slot     (slot)
	);

	assign out_byte = slot.data;
	assign kind     = slot.kind;
	assign last     = slot.last;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_commit_frees: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !in_take |=> !valid_s1)
		else $error("consumed item still held");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(data_s1) && $stable(end_s1))
		else $error("held item changed while stalled");

endmodule
`default_nettype wire

// ----- rtl/core/jsu_decode.sv -----
// Byte decoder: string state registers and the per-byte result logic.
`timescale 1ns / 1ps
`default_nettype none
module jsu_decode
	import jsu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       commit,
	input  wire logic [7:0] item_data,
	input  wire logic       item_end,
	input  wire logic       strict_mode,
	output dec_t            dec
);

	phase_t     phase_q, phase_d;
	logic       sq_q, sq_d;
	logic [1:0] hex_cnt_q, hex_cnt_d;
	logic [7:0] hex_val_q, hex_val_d;
	logic       hex_open_q, hex_open_d;
	logic       hex_seen_q, hex_seen_d;

	logic [7:0] delim;
	logic [4:0] hd;
	logic       is_ws;
	logic [7:0] hv_new;
	logic       hs_new;
	logic       ho_new;

	assign delim = sq_q ? CH_SQUOTE : CH_DQUOTE;
	assign hd    = hex_digit(item_data);
	assign is_ws = (item_data == CH_SPACE) || (item_data >= CH_HT && item_data <= CH_CR);

	// Leading hex digit run of a \u sequence
	always_comb begin
		hv_new = hex_val_q;
		hs_new = hex_seen_q;
		ho_new = hex_open_q;
		if (hex_open_q) begin
			if (hd[4]) begin
				hv_new = {hex_val_q[3:0], hd[3:0]};
				hs_new = 1'b1;
			end else begin
				ho_new = 1'b0;
			end
		end
	end

	// Results and next state
	always_comb begin
		dec        = '0;
		dec.r0     = '{data: 8'd0, kind: KIND_DATA, last: 1'b0};
		dec.r1     = '{data: 8'd0, kind: KIND_DATA, last: 1'b1};
		phase_d    = phase_q;
		sq_d       = sq_q;
		hex_cnt_d  = hex_cnt_q;
		hex_val_d  = hex_val_q;
		hex_open_d = hex_open_q;
		hex_seen_d = hex_seen_q;
		if (item_end) begin
			dec.any       = 1'b1;
			dec.r0.kind   = KIND_ERR;
			phase_d       = PH_IDLE;
			sq_d          = 1'b0;
			hex_cnt_d     = 2'd0;
			hex_val_d     = 8'd0;
			hex_open_d    = 1'b0;
			hex_seen_d    = 1'b0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (item_data == CH_DQUOTE) begin
						phase_d = PH_STR;
						sq_d    = 1'b0;
					end else if (item_data == CH_SQUOTE && !strict_mode) begin
						phase_d = PH_STR;
						sq_d    = 1'b1;
					end else if (!is_ws) begin
						dec.any     = 1'b1;
						dec.r0.kind = KIND_ERR;
					end
				end
				PH_STR: begin
					if (item_data == delim) begin
						dec.any     = 1'b1;
						dec.r0.kind = KIND_DONE;
						phase_d     = PH_IDLE;
						sq_d        = 1'b0;
						hex_cnt_d   = 2'd0;
						hex_val_d   = 8'd0;
						hex_open_d  = 1'b0;
						hex_seen_d  = 1'b0;
					end else if (item_data == CH_BSLASH) begin
						phase_d = PH_ESC;
					end else begin
						dec.any     = 1'b1;
						dec.r0.data = item_data;
					end
				end
				PH_ESC: begin
					phase_d = PH_STR;
					dec.any = 1'b1;
					case (item_data)
						CH_BSLASH, CH_SLASH: dec.r0.data = item_data;
						CH_B: dec.r0.data = CH_BS;
						CH_F: dec.r0.data = CH_FF;
						CH_N: dec.r0.data = CH_LF;
						CH_R: dec.r0.data = CH_CR;
						CH_T: dec.r0.data = CH_HT;
						CH_U: begin
							dec.any    = 1'b0;
							phase_d    = PH_HEX;
							hex_cnt_d  = 2'd0;
							hex_val_d  = 8'd0;
							hex_open_d = 1'b1;
							hex_seen_d = 1'b0;
						end
						default: begin
							if (item_data == delim) begin
								dec.r0.data = item_data;
							end else begin
								// unknown escape: backslash then the byte
								dec.two     = 1'b1;
								dec.r0.data = CH_BSLASH;
								dec.r1.data = item_data;
							end
						end
					endcase
				end
				PH_HEX: begin
					if (hex_cnt_q == HEX_LAST) begin
						dec.any     = hs_new;
						dec.r0.data = hv_new;
						phase_d     = PH_STR;
						hex_cnt_d   = 2'd0;
						hex_val_d   = 8'd0;
						hex_open_d  = 1'b0;
						hex_seen_d  = 1'b0;
					end else begin
						hex_cnt_d  = hex_cnt_q + 2'd1;
						hex_val_d  = hv_new;
						hex_open_d = ho_new;
						hex_seen_d = hs_new;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		dec.r0.last = !dec.two;
	end

	// State registers, advanced when the held item is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			sq_q       <= 1'b0;
			hex_cnt_q  <= 2'd0;
			hex_val_q  <= 8'd0;
			hex_open_q <= 1'b0;
			hex_seen_q <= 1'b0;
		end else if (commit) begin
			phase_q    <= phase_d;
			sq_q       <= sq_d;
			hex_cnt_q  <= hex_cnt_d;
			hex_val_q  <= hex_val_d;
			hex_open_q <= hex_open_d;
			hex_seen_q <= hex_seen_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/jsu_out_buf.sv -----
// Two-entry result register: output slot plus one pending slot.
`timescale 1ns / 1ps
`default_nettype none
module jsu_out_buf
	import jsu_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire logic    push_two,
	input  wire result_t r0,
	input  wire result_t r1,
	input  wire logic    stall,
	output logic         free,
	output logic         valid,
	output result_t      slot
);

	logic    out_valid_q;
	logic    pend_valid_q;
	result_t out_q;
	result_t pend_q;
	logic    take;

	assign take  = out_valid_q && !stall;
	// Output slot will be empty after this edge
	assign free  = !out_valid_q || (take && !pend_valid_q);
	assign valid = out_valid_q;
	assign slot  = out_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= push_two;
			end else if (take) begin
				out_valid_q  <= pend_valid_q;
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (push) begin
			out_q  <= r0;
			pend_q <= r1;
		end else if (take) begin
			out_q <= pend_q;
		end
	end

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("pending result without output result");

	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !out_q.last)
		else $error("first of a result pair marked last");

	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> free)
		else $error("result pushed over an occupied slot");

	a_pair_kept: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_two |=> pend_valid_q && out_valid_q)
		else $error("second result of a pair lost");

endmodule
`default_nettype wire

// ----- sim/json_string_unescape_tb.sv -----
// Self-checking testbench for the quoted string decoder json_string_unescape.
`timescale 1ns / 1ps
`default_nettype none
module json_string_unescape_tb;
	import jsu_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_ITEMS  = 500;

	// Characters used by the hex digit check and the generator
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] CH_LA = 8'h61;

	// One expected result transaction
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} decoded_t;

	// One input transaction; typed rows carry their own expected result
	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       typed;
		logic       has_res;
		kind_t      tk;
	} text_item_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       stream_end;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       last;

	// Decoder state mirrored by the predictor
	phase_t     str_phase;
	logic       str_single;
	logic       strict_mdl;
	logic [1:0] hx_cnt;
	logic [7:0] hx_val;
	logic       hx_open;
	logic       hx_seen;

	decoded_t   step_results [$];
	decoded_t   expected_results [$];
	text_item_t sent_items [$];

	int         err_count;
	int         n_sent;
	int         cycles;
	int         stall_cnt;
	logic       bursts_on;

	// Directed table: idle errors, extremes, escapes and \u handling in strict mode
	text_item_t dir_tab [29] = '{
		'{8'h78,     1'b0, 1'b1, 1'b1, KIND_ERR},   // 'x' while idle
		'{CH_SPACE,  1'b0, 1'b1, 1'b0, KIND_DATA},  // whitespace skipped
		'{CH_SQUOTE, 1'b0, 1'b1, 1'b1, KIND_ERR},   // single quote refused in strict mode
		'{8'hFF,     1'b0, 1'b1, 1'b1, KIND_ERR},
		'{8'h00,     1'b0, 1'b1, 1'b1, KIND_ERR},
		'{8'h00,     1'b1, 1'b1, 1'b1, KIND_ERR},   // end of stream while idle
		'{CH_DQUOTE, 1'b0, 1'b1, 1'b0, KIND_DATA},  // open string
		'{8'h00,     1'b0, 1'b0, 1'b0, KIND_DATA},
		'{8'hFF,     1'b0, 1'b0, 1'b0, KIND_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, 1'b0, KIND_DATA},
		'{CH_B,      1'b0, 1'b0, 1'b0, KIND_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, 1'b0, KIND_DATA},
		'{CH_F,      1'b0, 1'b0, 1'b0, KIND_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, 1'b0, KIND_DATA},
		'{CH_DQUOTE, 1'b0, 1'b0, 1'b0, KIND_DATA},  // escaped delimiter
		'{CH_BSLASH, 1'b0, 1'b0, 1'b0, KIND_DATA},
		'{8'h71,     1'b0, 1'b0, 1'b0, KIND_DATA},  // unknown escape, two results
		'{CH_BSLASH, 1'b0, 1'b0, 1'b0, KIND_DATA},
		'{CH_U,      1'b0, 1'b0, 1'b0, KIND_DATA},
		'{8'h61,     1'b0, 1'b0, 1'b0, KIND_DATA},
		'{8'h42,     1'b0, 1'b0, 1'b0, KIND_DATA},
		'{8'h2E,     1'b0, 1'b0, 1'b0, KIND_DATA},  // breaks the digit run
		'{8'h63,     1'b0, 1'b0, 1'b0, KIND_DATA},  // digit after the break, ignored
		'{CH_DQUOTE, 1'b0, 1'b1, 1'b1, KIND_DONE},  // close string
		'{CH_DQUOTE, 1'b0, 1'b1, 1'b0, KIND_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, 1'b0, KIND_DATA},
		'{CH_U,      1'b0, 1'b0, 1'b0, KIND_DATA},
		'{8'h7A,     1'b0, 1'b0, 1'b0, KIND_DATA},
		'{8'h00,     1'b1, 1'b1, 1'b1, KIND_ERR}    // end of stream inside \u
	};

	json_string_unescape u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.stream_end (stream_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.kind       (kind),
		.last       (last)
	);

	// Clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver stall bursts
	always @(posedge clk) begin
		if (bursts_on && stall_cnt == 0 && $urandom_range(0, 15) == 0)
			stall_cnt = $urandom_range(1, 18);
		out_stall <= (stall_cnt != 0);
		if (stall_cnt != 0)
			stall_cnt--;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t mismatch %s: got %02h, expected %02h", $realtime, what, got, want);
		err_count++;
	endtask

	function automatic void push_res(input logic [7:0] d, input kind_t k);
		decoded_t r;
		r = '{d, k, 1'b0};
		step_results.insert(step_results.size(), r);
	endfunction

	function automatic void clear_str();
		str_phase  = PH_IDLE;
		str_single = 1'b0;
		hx_cnt     = 2'd0;
		hx_val     = 8'h00;
		hx_open    = 1'b0;
		hx_seen    = 1'b0;
	endfunction

	// Decode one byte into step_results, updating the mirrored state
	function automatic void predict_decode(input logic [7:0] c, input logic fin);
		logic [7:0] dl;
		logic [7:0] nib;
		logic       dig;
		dl  = str_single ? CH_SQUOTE : CH_DQUOTE;
		nib = 8'h00;
		dig = 1'b1;
		if (fin) begin
			push_res(8'h00, KIND_ERR);
			clear_str();
		end else begin
			case (str_phase)
				PH_IDLE: begin
					if (c == CH_DQUOTE) begin
						str_phase  = PH_STR;
						str_single = 1'b0;
					end else if (c == CH_SQUOTE && !strict_mdl) begin
						str_phase  = PH_STR;
						str_single = 1'b1;
					end else if (!(c == CH_SPACE || (c >= CH_HT && c <= CH_CR))) begin
						push_res(8'h00, KIND_ERR);
					end
				end
				PH_STR: begin
					if (c == dl) begin
						push_res(8'h00, KIND_DONE);
						clear_str();
					end else if (c == CH_BSLASH) begin
						str_phase = PH_ESC;
					end else begin
						push_res(c, KIND_DATA);
					end
				end
				PH_ESC: begin
					str_phase = PH_STR;
					case (c)
						CH_BSLASH, CH_SLASH: push_res(c, KIND_DATA);
						CH_B: push_res(CH_BS, KIND_DATA);
						CH_F: push_res(CH_FF, KIND_DATA);
						CH_N: push_res(CH_LF, KIND_DATA);
						CH_R: push_res(CH_CR, KIND_DATA);
						CH_T: push_res(CH_HT, KIND_DATA);
						CH_U: begin
							str_phase = PH_HEX;
							hx_cnt    = 2'd0;
							hx_val    = 8'h00;
							hx_open   = 1'b1;
							hx_seen   = 1'b0;
						end
						default: begin
							if (c != dl)
								push_res(CH_BSLASH, KIND_DATA);
							push_res(c, KIND_DATA);
						end
					endcase
				end
				default: begin
					// \u body: only the leading run of hex digits counts
					if (c >= CH_0 && c <= CH_9)
						nib = c - CH_0;
					else if (c >= CH_LA && c <= CH_F)
						nib = c - CH_LA + 8'd10;
					else if (c >= CH_UA && c <= CH_UF)
						nib = c - CH_UA + 8'd10;
					else
						dig = 1'b0;
					if (hx_open) begin
						if (dig) begin
							hx_val  = {hx_val[3:0], nib[3:0]};
							hx_seen = 1'b1;
						end else begin
							hx_open = 1'b0;
						end
					end
					if (hx_cnt == HEX_LAST) begin
						if (hx_seen)
							push_res(hx_val, KIND_DATA);
						str_phase = PH_STR;
						hx_cnt    = 2'd0;
						hx_val    = 8'h00;
						hx_open   = 1'b0;
						hx_seen   = 1'b0;
					end else begin
						hx_cnt = hx_cnt + 2'd1;
					end
				end
			endcase
		end
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
	endfunction

	// Predict on accepted input transactions, check accepted result transactions
	always @(posedge clk) begin : monitor
		text_item_t s;
		decoded_t   e;
		decoded_t   t;
		if (arst_n) begin
			if (in_valid && !in_stall && sent_items.size() > 0) begin
				s = sent_items.pop_front();
				step_results.delete();
				predict_decode(s.b, s.fin);
				if (s.typed) begin
					if (s.has_res) begin
						t = '{8'h00, s.tk, 1'b1};
						expected_results.insert(expected_results.size(), t);
					end
				end else begin
					foreach (step_results[k])
						expected_results.insert(expected_results.size(), step_results[k]);
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, out_byte", out_byte, 8'h00);
				end else begin
					e = expected_results.pop_front();
					if (out_byte !== e.data)
						report_mismatch("out_byte", out_byte, e.data);
					if (kind !== e.kind)
						report_mismatch("kind", {6'd0, kind}, {6'd0, e.kind});
					if (last !== e.last)
						report_mismatch("last", {7'd0, last}, {7'd0, e.last});
				end
			end
		end
	end

	// Drive one input transaction and hold it until accepted
	task automatic send_item(input text_item_t s);
		if (bursts_on && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		sent_items.insert(sent_items.size(), s);
		in_valid   <= 1'b1;
		data_byte  <= s.b;
		stream_end <= s.fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		text_item_t s;
		s = '{b, fin, 1'b0, 1'b0, KIND_DATA};
		send_item(s);
	endtask

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10)
			return CH_0 + 8'(v);
		else if (v < 16)
			return CH_LA + 8'(v - 10);
		return CH_UA + 8'(v - 16);
	endfunction

	// One random string, mostly well formed, sometimes noise or cut short
	task automatic gen_string();
		logic [7:0] dl;
		int         sel;
		if ($urandom_range(0, 9) < 2) begin
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
		end else begin
			repeat ($urandom_range(0, 2))
				send_byte(CH_SPACE + 8'($urandom_range(0, 1)) * (CH_HT - CH_SPACE +
					8'($urandom_range(0, 4))), 1'b0);
			dl = (($urandom_range(0, 1) == 1 && !strict_mdl) || $urandom_range(0, 9) == 0)
				? CH_SQUOTE : CH_DQUOTE;
			send_byte(dl, 1'b0);
			repeat ($urandom_range(0, 10)) begin
				sel = $urandom_range(0, 9);
				if (sel < 5) begin
					send_byte(8'($urandom_range(0, 255)), 1'b0);
				end else if (sel < 8) begin
					send_byte(CH_BSLASH, 1'b0);
					case ($urandom_range(0, 9))
						0: send_byte(CH_BSLASH, 1'b0);
						1: send_byte(CH_SLASH, 1'b0);
						2: send_byte(CH_B, 1'b0);
						3: send_byte(CH_F, 1'b0);
						4: send_byte(CH_N, 1'b0);
						5: send_byte(CH_R, 1'b0);
						6: send_byte(CH_T, 1'b0);
						7: send_byte(CH_DQUOTE, 1'b0);
						8: send_byte(CH_SQUOTE, 1'b0);
						default: send_byte(8'($urandom_range(0, 255)), 1'b0);
					endcase
				end else begin
					send_byte(CH_BSLASH, 1'b0);
					send_byte(CH_U, 1'b0);
					repeat (4)
						send_byte(($urandom_range(0, 9) < 7) ? rand_hex_char()
							: 8'($urandom_range(0, 255)), 1'b0);
				end
			end
			// Close normally, or end the stream early
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end else if (sel == 1) begin
				send_byte(CH_BSLASH, 1'b0);
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				send_byte(dl, 1'b0);
			end
		end
	endtask

	// Stop sending and wait until every expected result has come out
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (sent_items.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_strict(input logic v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		strict_mdl = v;
	endtask

	// Main sequence
	initial begin : stimulus
		int target;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 1'b0;
		in_valid   = 1'b0;
		data_byte  = 8'h00;
		stream_end = 1'b0;
		out_stall  = 1'b0;
		err_count  = 0;
		n_sent     = 0;
		cycles     = 0;
		stall_cnt  = 0;
		bursts_on  = 1'b0;
		strict_mdl = 1'b1;
		clear_str();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		bursts_on = 1'b1;

		foreach (dir_tab[i])
			send_item(dir_tab[i]);

		// Random phases alternate the delimiter mode; the last runs without idling
		for (int ph = 0; ph < 4; ph++) begin
			drain_pipeline();
			set_strict(ph[0]);
			if (ph == 3)
				bursts_on = 1'b0;
			target = n_sent + PHASE_ITEMS;
			while (n_sent < target)
				gen_string();
		end

		drain_pipeline();
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- json_string_unescape.f -----
rtl/core/jsu_pkg.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_out_buf.sv
rtl/core/json_string_unescape.sv
sim/json_string_unescape_tb.sv
